// ===== rtl/page_framebuffer_text_bar_drawer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// page_framebuffer_text_bar_drawer_unit_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_TEXT_BAR_DRAWER_UNIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_TEXT_BAR_DRAWER_UNIT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define PFTBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define PFTBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pftbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pftbd_pkg
// Types, constants and the 5x7 font ROM for the page framebuffer drawer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pftbd_pkg;

    localparam int DEF_COLUMNS  = 128;
    localparam int DEF_PAGES    = 8;
    localparam int GLYPH_COLS   = 5;
    localparam int CHAR_ADVANCE = 6;

    localparam logic [7:0] BYTE_CAP   = 8'hFF;
    localparam logic [7:0] BYTE_FILL  = 8'h7E;
    localparam logic [7:0] BYTE_EMPTY = 8'h42;
    localparam logic [7:0] BYTE_BLANK = 8'h00;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_CHAR  = 2'd1,
        FUNC_BAR   = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STS_DONE = 2'd0,
        STS_CLIP = 2'd1,
        STS_PAGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_ZERO  = 2'd1,
        WR_GLYPH = 2'd2,
        WR_BAR   = 2'd3
    } wr_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ROW_CLEAR,
        ST_CHAR_WR,
        ST_BAR_WR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        func_t       func;
        logic [3:0]  page_sel;
        logic [6:0]  column;
        logic [7:0]  char_code;
        logic        first_char;
        logic [8:0]  bar_fraction;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  read_data;
        logic [7:0]  next_column;
    } out_item_t;

    typedef struct packed {
        logic    take;
        logic    dispatch;
        logic    clear_all;
        logic    cnt_clr;
        logic    cnt_inc;
        wr_sel_t wr_sel;
        logic    set_valid;
        logic    cursor_adv;
        logic    load_out;
    } pftbd_cmd_t;

    typedef struct packed {
        func_t op;
        logic  page_bad;
        logic  clip;
        logic  row_valid;
        logic  cnt_last_row;
        logic  cnt_last_glyph;
        logic  out_free;
    } pftbd_sts_t;

    typedef logic [0:GLYPH_COLS-1][7:0] glyph_t;

    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        logic [7:0] c;
        glyph_t     g;
        c = code;
        if (c >= 8'd97 && c <= 8'd122) begin
            c = c - 8'd32;
        end
        case (c)
            8'd32: g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            8'd33: g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
            8'd37: g = {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
            8'd39: g = {8'h00, 8'h05, 8'h03, 8'h00, 8'h00};
            8'd45: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            8'd46: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
            8'd47: g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
            8'd48: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
            8'd49: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            8'd50: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            8'd51: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
            8'd52: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            8'd53: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            8'd54: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
            8'd55: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            8'd56: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'd57: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
            8'd58: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
            8'd63: g = {8'h02, 8'h01, 8'h59, 8'h09, 8'h06};
            8'd65: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            8'd66: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            8'd67: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            8'd68: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
            8'd69: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            8'd70: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            8'd71: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            8'd72: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'd73: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'd74: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
            8'd75: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            8'd76: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            8'd77: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            8'd78: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            8'd79: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'd80: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            8'd81: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
            8'd82: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            8'd83: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            8'd84: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'd85: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'd86: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            8'd87: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            8'd88: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            8'd89: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            8'd90: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/page_framebuffer_text_bar_drawer_unit.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_text_bar_drawer_unit
// Page framebuffer with 5x7 character drawing, progress bar and readback.
// Clear, read and rejected items write nothing; a character writes its glyph,
// first blanking its row if its page is empty since reset or the last clear;
// a bar writes its whole row (one store write port, one byte per cycle). One
// item at a time; the next is taken in the cycle after the result is loaded.
// Reset clears cursor and page valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_framebuffer_text_bar_drawer_unit #(
    parameter int COLUMNS = pftbd_pkg::DEF_COLUMNS,
    parameter int PAGES   = pftbd_pkg::DEF_PAGES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pftbd_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pftbd_pkg::out_item_t  m_data
);
    import pftbd_pkg::*;

    pftbd_cmd_t cmd;
    pftbd_sts_t sts;

    pftbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pftbd_datapath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/pftbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pftbd_ctrl
// Sequencer: accepts one item, steps the datapath through its writes,
// hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pftbd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pftbd_pkg::pftbd_sts_t  sts,
    output pftbd_pkg::pftbd_cmd_t  cmd
);
    import pftbd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.op)
                    FUNC_CHAR: begin
                        if (sts.page_bad || sts.clip) begin
                            state_next = ST_RESULT;
                        end else if (!sts.row_valid) begin
                            state_next = ST_ROW_CLEAR;
                        end else begin
                            state_next = ST_CHAR_WR;
                        end
                    end
                    FUNC_BAR: begin
                        state_next = sts.page_bad ? ST_RESULT : ST_BAR_WR;
                    end
                    default: state_next = ST_RESULT;
                endcase
            end
            ST_ROW_CLEAR: begin
                if (sts.cnt_last_row) begin
                    state_next = ST_CHAR_WR;
                end
            end
            ST_CHAR_WR: begin
                if (sts.cnt_last_glyph) begin
                    state_next = ST_RESULT;
                end
            end
            ST_BAR_WR: begin
                if (sts.cnt_last_row) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_DISPATCH: begin
                cmd.dispatch  = 1'b1;
                cmd.cnt_clr   = 1'b1;
                cmd.clear_all = (sts.op == FUNC_CLEAR);
            end
            ST_ROW_CLEAR: begin
                cmd.wr_sel    = WR_ZERO;
                cmd.cnt_inc   = 1'b1;
                cmd.cnt_clr   = sts.cnt_last_row;
                cmd.set_valid = sts.cnt_last_row;
            end
            ST_CHAR_WR: begin
                cmd.wr_sel     = WR_GLYPH;
                cmd.cnt_inc    = 1'b1;
                cmd.cursor_adv = sts.cnt_last_glyph;
            end
            ST_BAR_WR: begin
                cmd.wr_sel    = WR_BAR;
                cmd.cnt_inc   = 1'b1;
                cmd.set_valid = sts.cnt_last_row;
            end
            ST_RESULT: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/pftbd_datapath.sv =====
// ----------------------------------------------------------------------------
// pftbd_datapath
// Frame store, page valid bits, cursor, sweep counter, byte generators
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pftbd_datapath #(
    parameter int COLUMNS = pftbd_pkg::DEF_COLUMNS,
    parameter int PAGES   = pftbd_pkg::DEF_PAGES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pftbd_pkg::in_item_t    s_data,
    input  pftbd_pkg::pftbd_cmd_t  cmd,
    output pftbd_pkg::pftbd_sts_t  sts,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pftbd_pkg::out_item_t   m_data
);
    import pftbd_pkg::*;

    localparam int DEPTH   = PAGES * COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int PAGE_IW = (PAGES > 1) ? $clog2(PAGES) : 1;

    in_item_t            item_reg;
    logic [7:0]          cursor_reg, cursor_next;
    logic [COL_W-1:0]    cnt_reg, cnt_next;
    logic [PAGES-1:0]    valid_reg, valid_next;
    status_t             status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           out_reg, out_next;
    logic [7:0]          mem [DEPTH];
    logic [7:0]          rdata_reg;

    logic                page_bad, clip, col_bad, row_valid, read_hit;
    logic [PAGE_IW-1:0]  page_idx;
    logic [8:0]          col_ext;
    logic [ADDR_W-1:0]   row_base, wr_addr, rd_addr;
    logic                wr_en;
    logic [7:0]          wr_data, bar_byte;
    logic [8:0]          frac_sat, filled, cursor_sum;
    logic [16:0]         fill_prod;
    glyph_t              glyph;

    // item decode
    assign page_bad  = {1'b0, item_reg.page_sel} >= 5'(PAGES);
    assign page_idx  = item_reg.page_sel[PAGE_IW-1:0];
    assign clip      = {1'b0, cursor_reg} >= 9'(COLUMNS - GLYPH_COLS);
    assign col_ext   = {2'b00, item_reg.column};
    assign col_bad   = col_ext >= 9'(COLUMNS);
    assign row_valid = page_bad ? 1'b0 : valid_reg[page_idx];
    assign read_hit  = (item_reg.func == FUNC_READ) && !page_bad && !col_bad && row_valid;
    assign row_base  = ADDR_W'(page_idx) * ADDR_W'(COLUMNS);
    assign rd_addr   = row_base + ADDR_W'(col_ext[COL_W-1:0]);

    // bar and glyph bytes
    assign frac_sat  = (item_reg.bar_fraction > 9'd256) ? 9'd256 : item_reg.bar_fraction;
    assign fill_prod = 17'(frac_sat) * 17'(COLUMNS);
    assign filled    = fill_prod[16:8];
    assign glyph     = glyph_lookup(item_reg.char_code);

    always_comb begin
        if (cnt_reg == '0 || cnt_reg == COL_W'(COLUMNS - 1)) begin
            bar_byte = BYTE_CAP;
        end else if (9'(cnt_reg) < filled) begin
            bar_byte = BYTE_FILL;
        end else begin
            bar_byte = BYTE_EMPTY;
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = row_base + ADDR_W'(cnt_reg);
        wr_data = BYTE_BLANK;
        case (cmd.wr_sel)
            WR_ZERO:  wr_data = BYTE_BLANK;
            WR_BAR:   wr_data = bar_byte;
            WR_GLYPH: begin
                wr_addr = row_base + ADDR_W'(cursor_reg[COL_W-1:0]) + ADDR_W'(cnt_reg);
                wr_data = glyph[cnt_reg[2:0]];
            end
            default:  wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // state updates
    assign cursor_sum = {1'b0, cursor_reg} + 9'(CHAR_ADVANCE);

    always_comb begin
        cursor_next = cursor_reg;
        if (cmd.take && s_data.func == FUNC_CHAR && s_data.first_char) begin
            cursor_next = {1'b0, s_data.column};
        end else if (cmd.cursor_adv) begin
            cursor_next = cursor_sum[8] ? 8'hFF : cursor_sum[7:0];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + COL_W'(1);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.clear_all) begin
            valid_next = '0;
        end else if (cmd.set_valid) begin
            valid_next[page_idx] = 1'b1;
        end
    end

    always_comb begin
        status_next = status_reg;
        if (cmd.dispatch) begin
            case (item_reg.func)
                FUNC_CLEAR: status_next = STS_DONE;
                FUNC_CHAR:  status_next = page_bad ? STS_PAGE : (clip ? STS_CLIP : STS_DONE);
                FUNC_BAR:   status_next = page_bad ? STS_PAGE : STS_DONE;
                FUNC_READ:  status_next = page_bad ? STS_PAGE : (col_bad ? STS_CLIP : STS_DONE);
                default:    status_next = STS_DONE;
            endcase
        end
    end

    always_comb begin
        out_next = out_reg;
        if (cmd.load_out) begin
            out_next.status      = status_reg;
            out_next.read_data   = read_hit ? rdata_reg : BYTE_BLANK;
            out_next.next_column = cursor_reg;
        end
    end

    assign m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg  <= '0;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cursor_reg  <= cursor_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg <= s_data;
        end
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign sts.op             = item_reg.func;
    assign sts.page_bad       = page_bad;
    assign sts.clip           = clip;
    assign sts.row_valid      = row_valid;
    assign sts.cnt_last_row   = (cnt_reg == COL_W'(COLUMNS - 1));
    assign sts.cnt_last_glyph = (cnt_reg == COL_W'(GLYPH_COLS - 1));
    assign sts.out_free       = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/pftbd_checker.sv =====
// ----------------------------------------------------------------------------
// pftbd_checker
// Port-level checks on the drawer unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_framebuffer_text_bar_drawer_unit_macros.svh"

module pftbd_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  pftbd_pkg::out_item_t  m_data
);
    import pftbd_pkg::*;

    `PFTBD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `PFTBD_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "second transfer taken while busy")
    `PFTBD_ASSERT_NOW(a_status_code, m_valid, m_data.status != 2'd3, "undefined status code")
    `PFTBD_ASSERT_NOW(a_data_zero, m_valid && m_data.status != STS_DONE, m_data.read_data == 8'h00, "read data set on failed item")

endmodule

bind page_framebuffer_text_bar_drawer_unit pftbd_checker u_pftbd_checker (.*);

// ===== tb/page_framebuffer_text_bar_drawer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_text_bar_drawer_unit_tb
// Self-checking bench for the page framebuffer drawer. A local shadow of the
// frame store and text cursor predicts every result. Directed items cover
// text, clipping, bad pages, bars and clear. Random phases then mix text
// runs, reads, bars and clears under several sender and receiver idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_framebuffer_text_bar_drawer_unit_tb;

    import pftbd_pkg::*;

    localparam int COLS         = DEF_COLUMNS;
    localparam int PGS          = DEF_PAGES;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 2 * COLS + 16;
    localparam int TIMEOUT_NS   = 25_000_000;
    localparam int FONT_ENTRIES = 45;
    localparam int PHASE_ITEMS  = 332;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // {code, col0, col1, col2, col3, col4}
    logic [47:0] font_rom [FONT_ENTRIES] = '{
        48'h20_0000000000, 48'h21_00005F0000, 48'h27_0005030000, 48'h25_2313086462,
        48'h2D_0808080808, 48'h2E_0060600000, 48'h2F_2010080402, 48'h3A_0036360000,
        48'h3F_0201590906, 48'h30_3E5149453E, 48'h31_00427F4000, 48'h32_4261514946,
        48'h33_2141454B31, 48'h34_1814127F10, 48'h35_2745454539, 48'h36_3C4A494930,
        48'h37_0171090503, 48'h38_3649494936, 48'h39_064949291E, 48'h41_7E1111117E,
        48'h42_7F49494936, 48'h43_3E41414122, 48'h44_7F4141221C, 48'h45_7F49494941,
        48'h46_7F09090901, 48'h47_3E4149497A, 48'h48_7F0808087F, 48'h49_00417F4100,
        48'h4A_2040413F01, 48'h4B_7F08142241, 48'h4C_7F40404040, 48'h4D_7F020C027F,
        48'h4E_7F0408107F, 48'h4F_3E4141413E, 48'h50_7F09090906, 48'h51_3E4151215E,
        48'h52_7F09192946, 48'h53_4649494931, 48'h54_01017F0101, 48'h55_3F4040403F,
        48'h56_1F2040201F, 48'h57_3F4038403F, 48'h58_6314081463, 48'h59_0708700807,
        48'h5A_6151494543
    };

    logic [7:0] frame_bytes [PGS][COLS];
    logic [7:0] text_cursor;
    out_item_t  pending_results [$];

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int n_clear         = 0;
    int n_char          = 0;
    int n_bar           = 0;
    int n_read          = 0;

    page_framebuffer_text_bar_drawer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [7:0] glyph_byte(input logic [7:0] code, input int idx);
        logic [7:0] c;
        logic [7:0] b;
        c = (code >= "a" && code <= "z") ? code - 8'd32 : code;
        b = BYTE_BLANK;
        for (int e = 0; e < FONT_ENTRIES; e++) begin
            if (font_rom[e][47:40] == c) begin
                b = font_rom[e][39 - 8 * idx -: 8];
            end
        end
        return b;
    endfunction

    function automatic out_item_t predict_frame_result(input in_item_t it);
        out_item_t r;
        int        frac;
        int        filled;
        r.status      = STS_DONE;
        r.read_data   = '0;
        case (it.func)
            FUNC_CLEAR: begin
                n_clear++;
                for (int p = 0; p < PGS; p++) begin
                    for (int c = 0; c < COLS; c++) begin
                        frame_bytes[p][c] = BYTE_BLANK;
                    end
                end
            end
            FUNC_CHAR: begin
                n_char++;
                if (it.first_char) begin
                    text_cursor = {1'b0, it.column};
                end
                if (it.page_sel >= PGS) begin
                    r.status = STS_PAGE;
                end else if (text_cursor >= COLS - GLYPH_COLS) begin
                    r.status = STS_CLIP;
                end else begin
                    for (int k = 0; k < GLYPH_COLS; k++) begin
                        frame_bytes[it.page_sel][text_cursor + k] = glyph_byte(it.char_code, k);
                    end
                    text_cursor = (text_cursor > 255 - CHAR_ADVANCE) ? 8'd255
                                                                     : 8'(text_cursor + CHAR_ADVANCE);
                end
            end
            FUNC_BAR: begin
                n_bar++;
                if (it.page_sel >= PGS) begin
                    r.status = STS_PAGE;
                end else begin
                    frac   = (it.bar_fraction > 256) ? 256 : it.bar_fraction;
                    filled = (frac * COLS) >> 8;
                    for (int c = 0; c < COLS; c++) begin
                        if (c == 0 || c == COLS - 1) begin
                            frame_bytes[it.page_sel][c] = BYTE_CAP;
                        end else if (c < filled) begin
                            frame_bytes[it.page_sel][c] = BYTE_FILL;
                        end else begin
                            frame_bytes[it.page_sel][c] = BYTE_EMPTY;
                        end
                    end
                end
            end
            default: begin
                n_read++;
                if (it.page_sel >= PGS) begin
                    r.status = STS_PAGE;
                end else if (it.column >= COLS) begin
                    r.status = STS_CLIP;
                end else begin
                    r.read_data = frame_bytes[it.page_sel][it.column];
                end
            end
        endcase
        r.next_column = text_cursor;
        return r;
    endfunction

    function automatic in_item_t make_item(input func_t f, input int page, input int col,
                                           input int code, input bit first, input int frac);
        in_item_t it;
        it.func         = f;
        it.page_sel     = 4'(page);
        it.column       = 7'(col);
        it.char_code    = 8'(code);
        it.first_char   = first;
        it.bar_fraction = 9'(frac);
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.func         = func_t'($urandom_range(3));
        it.page_sel     = 4'($urandom_range(15));
        it.column       = 7'($urandom_range(127));
        it.char_code    = 8'($urandom_range(255));
        it.first_char   = 1'($urandom_range(1));
        it.bar_fraction = 9'($urandom_range(511));
        return it;
    endfunction

    function automatic int rand_page();
        return ($urandom_range(99) < 10) ? $urandom_range(15) : $urandom_range(PGS - 1);
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_frame_result(it));
        items_sent++;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, m_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_data.status != want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.read_data != want.read_data) begin
                    $display("%0t: read_data mismatch expected %h actual %h",
                             $time, want.read_data, m_data.read_data);
                    fail_count++;
                end
                if (m_data.next_column != want.next_column) begin
                    $display("%0t: next_column mismatch expected %0d actual %0d",
                             $time, want.next_column, m_data.next_column);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset_state();
        send_item(make_item(FUNC_READ, 0, 0, 0, 1'b0, 0));
        send_item(make_item(FUNC_READ, 15, 127, 255, 1'b1, 511));
    endtask

    task automatic test_text_draw();
        send_item(make_item(FUNC_CHAR, 0, 0, "A", 1'b1, 0));
        send_item(make_item(FUNC_CHAR, 0, 0, "z", 1'b0, 0));
        // no glyph for these two
        send_item(make_item(FUNC_CHAR, 0, 0, "~", 1'b0, 0));
        send_item(make_item(FUNC_CHAR, 0, 127, 255, 1'b0, 511));
        // last start column that still fits, then clipped
        send_item(make_item(FUNC_CHAR, 7, COLS - GLYPH_COLS - 1, "9", 1'b1, 0));
        send_item(make_item(FUNC_CHAR, 7, 0, "B", 1'b0, 0));
        send_item(make_item(FUNC_CHAR, 3, COLS - GLYPH_COLS, "C", 1'b1, 0));
        // bad page still loads the cursor but does not advance it
        send_item(make_item(FUNC_CHAR, 15, 127, "!", 1'b1, 0));
        send_item(make_item(FUNC_CHAR, PGS, 0, "0", 1'b0, 0));
        send_item(make_item(FUNC_READ, 0, 7, 0, 1'b0, 0));
        send_item(make_item(FUNC_READ, 7, 126, 0, 1'b0, 0));
    endtask

    task automatic test_bar_draw();
        send_item(make_item(FUNC_BAR, 1, 0, 0, 1'b0, 0));
        send_item(make_item(FUNC_READ, 1, 1, 0, 1'b0, 0));
        send_item(make_item(FUNC_BAR, 2, 0, 0, 1'b0, 511));
        send_item(make_item(FUNC_READ, 2, 126, 0, 1'b0, 0));
        send_item(make_item(FUNC_BAR, 5, 0, 0, 1'b0, 255));
        send_item(make_item(FUNC_READ, 5, 126, 0, 1'b0, 0));
        send_item(make_item(FUNC_BAR, 3, 0, 0, 1'b0, 257));
        send_item(make_item(FUNC_BAR, 12, 0, 0, 1'b0, 256));
    endtask

    task automatic test_clear();
        send_item(make_item(FUNC_CLEAR, 0, 0, 0, 1'b0, 0));
        send_item(make_item(FUNC_READ, 2, 64, 0, 1'b0, 0));
    endtask

    task automatic send_text_run();
        in_item_t it;
        int       page;
        int       start;
        int       len;
        int       col;
        page  = rand_page();
        start = ($urandom_range(99) < 85) ? $urandom_range(COLS - GLYPH_COLS - 1)
                                          : $urandom_range(COLS - 1);
        len   = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            it            = random_item();
            it.func       = FUNC_CHAR;
            it.page_sel   = 4'(page);
            it.first_char = (k == 0) || ($urandom_range(99) < 5);
            if (k == 0) begin
                it.column = 7'(start);
            end
            if ($urandom_range(99) < 70) begin
                it.char_code = 8'($urandom_range(32, 122));
            end
            send_item(it);
        end
        if (page < PGS && $urandom_range(99) < 50) begin
            col         = start + $urandom_range(len * CHAR_ADVANCE);
            it          = random_item();
            it.func     = FUNC_READ;
            it.page_sel = 4'(page);
            it.column   = 7'((col > COLS - 1) ? COLS - 1 : col);
            send_item(it);
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        in_item_t it;
        int       stop_at;
        int       pick;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        stop_at         = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            it   = random_item();
            if (pick < 40) begin
                send_text_run();
            end else begin
                if (pick < 75) begin
                    it.func     = FUNC_READ;
                    it.page_sel = 4'(rand_page());
                end else if (pick < 87) begin
                    it.func     = FUNC_BAR;
                    it.page_sel = 4'(rand_page());
                    if ($urandom_range(1)) begin
                        it.bar_fraction = 9'($urandom_range(256));
                    end
                end else if (pick < 90) begin
                    it.func = FUNC_CLEAR;
                end
                send_item(it);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < PGS; p++) begin
            for (int c = 0; c < COLS; c++) begin
                frame_bytes[p][c] = BYTE_BLANK;
            end
        end
        text_cursor = '0;

        test_reset_state();
        test_text_draw();
        test_bar_draw();
        test_clear();
        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(48, 0, PHASE_ITEMS);
        test_random_traffic(0, 48, PHASE_ITEMS);
        test_random_traffic(28, 28, PHASE_ITEMS);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d transfers: %0d clear, %0d char, %0d bar, %0d read.",
                 items_sent, n_clear, n_char, n_bar, n_read);
        $display("Checked %0d results over four idle/stall mixes, %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
